FILE: hw/rtl/sha256_pkg.sv
package sha256_pkg;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_INIT,
        t_ST_ROUND,
        t_ST_ADD,
        t_ST_OUT
    } t_state;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

FILE: hw/rtl/sha256_hash.sv
// Byte-serial SHA-256. One request per byte on s_axis (tdata = data byte,
// tuser = {last, byte_valid}). A byte that does not complete a 64-byte block
// is only stored; a byte that completes one, or a last request, runs the
// compression on one shared round unit: an init state, the 64 rounds and a
// chain update per block, during which s_axis is not ready. A last request
// may need two padded blocks. The digest then leaves on m_axis as eight
// words, word 0 first (tdata = digest word, tuser = word index, tlast on
// word 7); the block waits on tready there and then accepts the next
// message.
module sha256_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] byte_valid, [1] last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    sha256_pkg::t_state r_state, n_state;

    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h7;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic        r_final;   // current compression is the last padded block
    logic        r_second;  // a second padded block is pending
    logic [2:0]  r_oidx;

    logic        acc;
    logic [3:0]  widx;
    logic [4:0]  sh;
    logic [31:0] wcur, s0, s1, wnew, t1, t2, ep, ap;
    logic [31:0] x15, x2;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == sha256_pkg::t_ST_IDLE);
    assign m_axis_tvalid = (r_state == sha256_pkg::t_ST_OUT);
    assign m_axis_tdata  = r_h[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // shared round unit
    always_comb begin
        x15  = r_w[r_rnd[3:0] + 4'd1];
        x2   = r_w[r_rnd[3:0] + 4'd14];
        s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        wnew = r_w[r_rnd[3:0]] + s0 + r_w[r_rnd[3:0] + 4'd9] + s1;
        wcur = (r_rnd < 6'd16) ? r_w[r_rnd[3:0]] : wnew;
        ep   = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
        ap   = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
        t1   = r_h7 + sha256_pkg::KTAB[r_rnd] + wcur + ep + ((r_e & r_f) ^ (~r_e & r_g));
        t2   = ap + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    assign widx = r_fill[5:2];
    assign sh   = 5'd24 - {r_fill[1:0], 3'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha256_pkg::t_ST_IDLE: begin
                if (acc && (s_axis_tuser[1] ||
                            (s_axis_tuser[0] && r_fill == 6'd63))) begin
                    n_state = sha256_pkg::t_ST_INIT;
                end
            end
            sha256_pkg::t_ST_INIT:  n_state = sha256_pkg::t_ST_ROUND;
            sha256_pkg::t_ST_ROUND: begin
                if (r_rnd == 6'd63) n_state = sha256_pkg::t_ST_ADD;
            end
            sha256_pkg::t_ST_ADD: begin
                if (r_final)       n_state = sha256_pkg::t_ST_OUT;
                else if (r_second) n_state = sha256_pkg::t_ST_INIT;
                else               n_state = sha256_pkg::t_ST_IDLE;
            end
            sha256_pkg::t_ST_OUT: begin
                if (m_axis_tready && r_oidx == 3'd7) n_state = sha256_pkg::t_ST_IDLE;
            end
            default: n_state = sha256_pkg::t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_h[k] <= sha256_pkg::IV[k];
            r_fill   <= '0;
            r_len    <= '0;
            r_rnd    <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_oidx   <= '0;
        end else begin
            case (r_state)
                sha256_pkg::t_ST_IDLE: begin
                    if (acc) begin
                        logic [5:0]  f;
                        logic [63:0] len;
                        logic [31:0] wd;
                        logic        pad;
                        f   = r_fill;
                        len = r_len;
                        wd  = r_w[widx];
                        if (s_axis_tuser[0]) begin
                            wd  = (wd & ~(32'hFF << sh)) | ({24'd0, s_axis_tdata} << sh);
                            len = len + 64'd8;
                            f   = f + 6'd1;
                        end
                        // a full block first compresses unpadded
                        pad = !(s_axis_tuser[0] && f == 6'd0);
                        r_len  <= len;
                        r_fill <= f;
                        r_rnd  <= '0;
                        if (s_axis_tuser[1]) begin
                            // pad: marker byte at fill point, zeros after
                            for (int j = 0; j < 16; j++) begin
                                logic [31:0] v;
                                v = (j == 32'(widx) && s_axis_tuser[0]) ? wd : r_w[j];
                                if (pad) begin
                                    for (int b = 0; b < 4; b++) begin
                                        if (j * 4 + b == 32'(f))
                                            v[31 - 8 * b -: 8] = sha256_pkg::PAD_BYTE;
                                        else if (j * 4 + b > 32'(f))
                                            v[31 - 8 * b -: 8] = 8'd0;
                                    end
                                    if (f <= 6'd55 && j == 14) v = len[63:32];
                                    if (f <= 6'd55 && j == 15) v = len[31:0];
                                end
                                r_w[j] <= v;
                            end
                            r_final  <= pad && f <= 6'd55;
                            r_second <= !pad || f > 6'd55;
                        end else begin
                            if (s_axis_tuser[0]) r_w[widx] <= wd;
                            r_final  <= 1'b0;
                            r_second <= 1'b0;
                        end
                    end
                end
                sha256_pkg::t_ST_INIT: begin
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                    r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_h7 <= r_h[7];
                    r_rnd <= '0;
                end
                sha256_pkg::t_ST_ROUND: begin
                    if (r_rnd >= 6'd16) r_w[r_rnd[3:0]] <= wnew;
                    r_h7 <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    r_rnd <= r_rnd + 6'd1;
                end
                sha256_pkg::t_ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
                    r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_h7;
                    r_oidx <= '0;
                    if (!r_final && r_second) begin
                        // second padded block: marker if block was full, length
                        for (int j = 0; j < 14; j++) r_w[j] <= '0;
                        if (r_fill == 6'd0) r_w[0] <= {sha256_pkg::PAD_BYTE, 24'd0};
                        r_w[14] <= r_len[63:32];
                        r_w[15] <= r_len[31:0];
                        r_final  <= 1'b1;
                        r_second <= 1'b0;
                    end
                end
                sha256_pkg::t_ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int k = 0; k < 8; k++) r_h[k] <= sha256_pkg::IV[k];
                            r_fill  <= '0;
                            r_len   <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
    a_round_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::t_ST_ROUND && r_rnd != 6'd63) |=>
        (r_state == sha256_pkg::t_ST_ROUND)) else $error("round loop broke");
    a_out_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (r_oidx == 3'd0)) else $error("digest not at word 0");
    a_fill_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_fill == 6'd0))
        else $error("fill not cleared");

endmodule
